FILE: src/indexed_ordered_list_assert.svh
// ----------------------------------------------------------------------------
// indexed ordered list assertion macros
// shared assertion wrappers for the list checker
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ASSERT_SVH

// property checked outside reset only
`define IOL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// property checked at every edge, reset included
`define IOL_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

FILE: src/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg
// types and constants shared by the indexed ordered list
// ----------------------------------------------------------------------------
package iol_pkg;

	localparam int POS_W   = 7;
	localparam int VAL_W   = 32;
	localparam int GROUP   = 8;
	localparam int GIDX_W  = 3;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_FIND   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_RANGE    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	// update broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [POS_W-1:0]  pos;
		logic [VAL_W-1:0]  val;
	} cmd_t;

	// registered summary of one group of cells
	typedef struct packed {
		logic              any_hit;
		logic [GIDX_W-1:0] first;
		logic [VAL_W-1:0]  rd_val;
	} grp_t;

endpackage

FILE: src/iol_if.sv
// ----------------------------------------------------------------------------
// iol_req_if / iol_rsp_if
// valid/ready channels for list requests and results
// ----------------------------------------------------------------------------
interface iol_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [6:0]         position;
	logic signed [31:0] value_in;

	modport source (output valid, kind, position, value_in, input ready);
	modport sink   (input valid, kind, position, value_in, output ready);
endinterface

interface iol_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [31:0] value_out;
	logic signed [6:0]  found_index;
	logic [6:0]         entry_count;

	modport source (output valid, status, value_out, found_index, entry_count,
		input ready);
	modport sink   (input valid, status, value_out, found_index, entry_count,
		output ready);
endinterface

FILE: src/iol_cell.sv
// ----------------------------------------------------------------------------
// iol_cell
// one list slot: shifts with its neighbours, compares and selects
// ----------------------------------------------------------------------------
module iol_cell import iol_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 7,
	parameter int PW  = 7
) (
	input  logic             clk,
	input  cmd_t             cmd,
	input  logic [CW-1:0]    count,
	input  logic [VAL_W-1:0] prev,
	input  logic [VAL_W-1:0] next,
	output logic [VAL_W-1:0] q,
	output logic             hit,
	output logic             sel
);

	localparam logic [PW-1:0] MY = PW'(IDX);

	logic [PW-1:0]    pos_x;
	logic [PW-1:0]    cnt_x;
	logic [VAL_W-1:0] data_q;

	assign pos_x = PW'(cmd.pos);
	assign cnt_x = PW'(count);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY == pos_x) begin
				data_q <= cmd.val;
			end else if (MY > pos_x) begin
				data_q <= prev;
			end
		end else if (cmd.rem && (MY >= pos_x)) begin
			data_q <= next;
		end
	end

	assign q   = data_q;
	assign hit = (MY < cnt_x) && (data_q == cmd.val);
	assign sel = (MY == pos_x);

endmodule

FILE: src/iol_group.sv
// ----------------------------------------------------------------------------
// iol_group
// first reduction level: summarises eight cells into a register
// ----------------------------------------------------------------------------
module iol_group import iol_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [GROUP-1:0] hit,
	input  logic [GROUP-1:0] sel,
	input  logic [VAL_W-1:0] value [GROUP],
	output grp_t             summary_s1
);

	grp_t nxt;

	always_comb begin
		nxt = '0;
		for (int j = GROUP - 1; j >= 0; j--) begin
			if (hit[j]) begin
				nxt.any_hit = 1'b1;
				nxt.first   = GIDX_W'(j);
			end
			if (sel[j]) begin
				nxt.rd_val = nxt.rd_val | value[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			summary_s1 <= nxt;
		end
	end

endmodule

FILE: src/indexed_ordered_list.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list
// ordered list of signed words with insert, remove, read and find by index
// ----------------------------------------------------------------------------
// usage
//   req carries kind, position and value_in; rsp returns status, value_out,
//   found_index and entry_count, exactly one result per request transfer.
//   the list lives in a row of CAPACITY cells; insert and remove shift the
//   cells from the position onward towards or away from their neighbours in
//   the edge of the transfer, so the list and count are updated at once.
//   read data and find matches are gathered in two steps: eight cells to a
//   group register at the request transfer, then the group registers into
//   the result register at the next edge.
// flow
//   a request passes the group registers and the result register before its
//   result is offered on rsp. one request is worked on at a time; req.ready is
//   low until its result transfer, so the block does not take a new request
//   before the last result has gone.
//   the group-to-result combine, a priority pick over CAPACITY/8 groups
//   (rounded up), sets the clock.
// reset
//   arst_n clears the count and all valid flags; cell contents are not
//   reset and are never read beyond the count.
// stalls
//   while rsp.ready is low the result holds and no request is taken.
// ----------------------------------------------------------------------------
module indexed_ordered_list import iol_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	iol_req_if.sink   req,
	iol_rsp_if.source rsp
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int PW   = (CW > POS_W) ? CW : POS_W;
	localparam int NG   = (CAPACITY + GROUP - 1) / GROUP;
	localparam int NGW  = (NG > 1) ? $clog2(NG) : 1;
	localparam int FXW  = (NGW + GIDX_W > POS_W) ? NGW + GIDX_W : POS_W;

	// control and count
	logic          accept;
	kind_t         kind;
	status_t       status_now;
	cmd_t          cmd;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic [PW-1:0] pos_x;
	logic [PW-1:0] cnt_x;

	// first stage: operation that owns the group registers
	logic          valid_s1;
	kind_t         kind_s1;
	status_t       status_s1;
	logic [CW-1:0] count_s1;

	// result register
	logic               out_valid_q;
	status_t            status_q;
	logic [VAL_W-1:0]   value_q;
	logic [POS_W-1:0]   index_q;
	logic [POS_W-1:0]   entry_count_q;

	// cell row and group summaries
	logic [VAL_W-1:0] cell_q   [CAPACITY];
	logic [VAL_W-1:0] pad_val  [NG*GROUP];
	logic [NG*GROUP-1:0] pad_hit;
	logic [NG*GROUP-1:0] pad_sel;
	grp_t             grp_s1   [NG];

	assign kind   = kind_t'(req.kind);
	assign accept = req.valid && req.ready;
	assign pos_x  = PW'(req.position);
	assign cnt_x  = PW'(count_q);

	// only one request in flight
	assign req.ready = !valid_s1 && !out_valid_q;

	// status and new count known at the request transfer, except for find
	always_comb begin
		status_now = ST_OK;
		count_nxt  = count_q;
		cmd.ins    = 1'b0;
		cmd.rem    = 1'b0;
		cmd.pos    = req.position;
		cmd.val    = req.value_in;
		case (kind)
			KIND_INSERT: begin
				if (count_q >= CW'(CAPACITY)) begin
					status_now = ST_FULL;
				end else if (count_q == '0) begin
					// empty list: position ignored, value goes to the head
					cmd.pos   = '0;
					cmd.ins   = accept;
					count_nxt = count_q + CW'(1);
				end else if (pos_x > cnt_x) begin
					status_now = ST_RANGE;
				end else begin
					cmd.ins   = accept;
					count_nxt = count_q + CW'(1);
				end
			end
			KIND_REMOVE: begin
				if (count_q == '0) begin
					status_now = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					status_now = ST_RANGE;
				end else begin
					cmd.rem   = accept;
					count_nxt = count_q - CW'(1);
				end
			end
			KIND_READ: begin
				if (pos_x >= cnt_x) begin
					status_now = ST_RANGE;
				end
			end
			KIND_FIND: begin
				status_now = ST_NOTFOUND;
			end
			default: begin
				status_now = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// row of cells, each handing its word to a neighbour on a shift
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] prev_w;
		logic [VAL_W-1:0] next_w;

		if (i == 0) begin : g_head
			assign prev_w = req.value_in;
		end else begin : g_body
			assign prev_w = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_w = cell_q[i];
		end else begin : g_mid
			assign next_w = cell_q[i+1];
		end

		iol_cell #(
			.IDX (i),
			.CW  (CW),
			.PW  (PW)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.count (count_q),
			.prev  (prev_w),
			.next  (next_w),
			.q     (cell_q[i]),
			.hit   (pad_hit[i]),
			.sel   (pad_sel[i])
		);
		assign pad_val[i] = cell_q[i];
	end

	// unused slots of the last group never match or select
	for (genvar i = CAPACITY; i < NG*GROUP; i++) begin : g_pad
		assign pad_hit[i] = 1'b0;
		assign pad_sel[i] = 1'b0;
		assign pad_val[i] = '0;
	end

	// first reduction level
	for (genvar g = 0; g < NG; g++) begin : g_grp
		iol_group u_group (
			.clk        (clk),
			.en         (accept),
			.hit        (pad_hit[g*GROUP +: GROUP]),
			.sel        (pad_sel[g*GROUP +: GROUP]),
			.value      (pad_val[g*GROUP : g*GROUP + GROUP - 1]),
			.summary_s1 (grp_s1[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			status_s1 <= status_now;
			count_s1  <= count_nxt;
		end
	end

	// second reduction level: first matching group, selected read word
	logic               any_hit;
	logic [FXW-1:0]     idx_full;
	logic [VAL_W-1:0]   rd_val;
	status_t            status_fin;
	logic [VAL_W-1:0]   value_fin;
	logic [POS_W-1:0]   index_fin;
	logic [FXW-1:0]     count_wide;

	always_comb begin
		any_hit  = 1'b0;
		idx_full = '0;
		rd_val   = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_s1[g].any_hit) begin
				any_hit  = 1'b1;
				idx_full = FXW'(g * GROUP) + FXW'(grp_s1[g].first);
			end
			rd_val = rd_val | grp_s1[g].rd_val;
		end
	end

	always_comb begin
		status_fin = status_s1;
		index_fin  = '1;
		if (kind_s1 == KIND_FIND && any_hit) begin
			status_fin = ST_OK;
			index_fin  = idx_full[POS_W-1:0];
		end
		if (status_fin != ST_OK) begin
			value_fin = '1;
		end else if (kind_s1 == KIND_REMOVE || kind_s1 == KIND_READ) begin
			value_fin = rd_val;
		end else begin
			value_fin = '0;
		end
	end

	assign count_wide = FXW'(count_s1);

	// result register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q      <= status_fin;
			value_q       <= value_fin;
			index_q       <= index_fin;
			entry_count_q <= count_wide[POS_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.value_out   = value_q;
	assign rsp.found_index = index_q;
	assign rsp.entry_count = entry_count_q;

endmodule

FILE: src/iol_checker.sv
// ----------------------------------------------------------------------------
// iol_checker
// port-level checks of the list, bound to the top level
// ----------------------------------------------------------------------------
`include "indexed_ordered_list_assert.svh"

module iol_checker import iol_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [31:0] rsp_value_out,
	input logic [6:0]  rsp_found_index
);

	logic rsp_failed;
	logic err_filled;
	logic rsp_stall;

	assign rsp_failed = rsp_valid && (rsp_status != ST_OK);
	assign err_filled = (&rsp_value_out) && (&rsp_found_index);
	assign rsp_stall  = rsp_valid && !rsp_ready;

	// no result can show while reset is applied
	`IOL_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !rsp_valid, "result valid in reset")

	// a request transfer is always followed by its result
	`IOL_ASSERT(a_latency, clk, arst_n, req_valid && req_ready |-> ##2 rsp_valid, "result late")

	// no new request while one is still in flight
	`IOL_ASSERT(a_single, clk, arst_n, req_valid && req_ready |=> !req_ready, "overlapping requests")

	// a failed operation reports all-ones value and index
	`IOL_ASSERT(a_err_fill, clk, arst_n, rsp_failed |-> err_filled, "error fill wrong")

	// a stalled result stays offered with its value unchanged
	`IOL_ASSERT(a_hold, clk, arst_n, rsp_stall |=> rsp_valid && $stable(rsp_value_out), "stall lost")

endmodule

bind indexed_ordered_list iol_checker u_iol_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_value_out   (rsp.value_out),
	.rsp_found_index (rsp.found_index)
);
